### hw/rtl/modexp_pkg.sv
// Shared types and constants of the modular exponentiation block.
package modexp_pkg;

  // Width of the base and result fields on the streaming channels.
  localparam int DATA_W = 32;

  // Width of the configuration register index.
  localparam int CFG_INDEX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_BIT,
    ST_MUL_ACC,
    ST_SQ_START,
    ST_MUL_SQ,
    ST_FINISH
  } ctl_state_t;

  // Datapath operations.
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_START,
    DP_MUL_STEP,
    DP_PUBLISH
  } dp_op_t;

  // Operand pair and destination of a modular multiplication.
  typedef enum logic {
    SEL_ACC,
    SEL_SQ
  } mul_sel_t;

  typedef struct packed {
    dp_op_t   op;
    mul_sel_t sel;
    logic     shift_exp;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_last;
    logic exp_bit;
    logic exp_done;
  } dp_status_t;

endpackage

### hw/rtl/modexp_ifs.sv
// Channel interfaces of the modular exponentiation block.
interface modexp_base_if;
  logic                            valid;
  logic                            ready;
  logic [modexp_pkg::DATA_W-1:0]   base_value;

  modport source (output valid, output base_value, input ready);
  modport sink (input valid, input base_value, output ready);
endinterface

interface modexp_result_if;
  logic                            valid;
  logic                            ready;
  logic [modexp_pkg::DATA_W-1:0]   power_result;

  modport source (output valid, output power_result, input ready);
  modport sink (input valid, input power_result, output ready);
endinterface

interface modexp_cfg_if #(
  parameter int WORD_BITS = 32
);
  logic                                 valid;
  logic                                 ready;
  logic [modexp_pkg::CFG_INDEX_W-1:0]   index;
  logic [WORD_BITS-1:0]                 data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: base^exponent mod modulus.
//
//   Channel   Dir   Beat contents                Accepted when
//   operand   in    base_value [31:0]            operand.valid && operand.ready
//   result    out   power_result [31:0]          result.valid && result.ready
//   cfg       in    index (0 exponent, 1 modulus), data [WORD_BITS-1:0]
//                                                cfg.valid && cfg.ready
//
// One base is processed at a time. A multiply first reduces the base; then each
// of the W = WORD_BITS exponent bits costs a multiply into the accumulator if it
// is set and then a squaring. The next base can be accepted once the result
// register has been loaded. The multiplier runs one bit-serial modular multiply
// step per cycle, W steps per multiply.
// Reset (rst, synchronous) sets the exponent to 0 and the modulus to 1 and
// empties the result register. A finished result waits in the output register;
// while it is not taken the next item can be accepted and computed, and only
// its own completion waits for the register to free up. The cfg channel is
// always ready; writes are expected only while no item is in flight.
module modular_exponentiation #(
  parameter int WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  modexp_base_if.sink            operand,
  modexp_result_if.source        result,
  modexp_cfg_if.sink             cfg
);

  localparam int DW = modexp_pkg::DATA_W;

  modexp_pkg::dp_cmd_t     cmd;
  modexp_pkg::dp_status_t  status;
  logic [WORD_BITS-1:0]    base_w;
  logic [WORD_BITS-1:0]    result_w;

  assign cfg.ready = 1'b1;

  // The base field is 32 bits wide; the arithmetic runs at WORD_BITS. The
  // casts zero-extend or truncate as the two widths require.
  assign base_w              = WORD_BITS'(operand.base_value);
  assign result.power_result = DW'(result_w);

  modexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operand.valid),
    .in_ready  (operand.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  modexp_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .base_value (base_w),
    .cmd        (cmd),
    .status     (status),
    .result     (result_w)
  );

endmodule

### hw/rtl/modexp_ctrl.sv
// Sequencing state machine of the modular exponentiation block.
module modexp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  modexp_pkg::dp_status_t status,
  output modexp_pkg::dp_cmd_t    cmd
);

  modexp_pkg::ctl_state_t state;
  modexp_pkg::ctl_state_t state_next;
  logic                   publish;
  logic                   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= modexp_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign publish        = (state == modexp_pkg::ST_FINISH) && (!out_valid || out_ready);
  assign out_valid_next = publish || (out_valid && !out_ready);

  always_comb begin
    state_next = state;
    case (state)
      modexp_pkg::ST_IDLE: begin
        if (in_valid) state_next = modexp_pkg::ST_REDUCE;
      end
      modexp_pkg::ST_REDUCE: begin
        if (status.mul_last) state_next = modexp_pkg::ST_BIT;
      end
      modexp_pkg::ST_BIT: begin
        state_next = status.exp_bit ? modexp_pkg::ST_MUL_ACC : modexp_pkg::ST_MUL_SQ;
      end
      modexp_pkg::ST_MUL_ACC: begin
        if (status.mul_last) state_next = modexp_pkg::ST_SQ_START;
      end
      modexp_pkg::ST_SQ_START: begin
        state_next = modexp_pkg::ST_MUL_SQ;
      end
      modexp_pkg::ST_MUL_SQ: begin
        if (status.mul_last) begin
          state_next = status.exp_done ? modexp_pkg::ST_FINISH : modexp_pkg::ST_BIT;
        end
      end
      modexp_pkg::ST_FINISH: begin
        if (publish) state_next = modexp_pkg::ST_IDLE;
      end
      default: state_next = modexp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.op        = modexp_pkg::DP_NOP;
    cmd.sel       = modexp_pkg::SEL_SQ;
    cmd.shift_exp = 1'b0;
    case (state)
      modexp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = modexp_pkg::DP_LOAD;
      end
      modexp_pkg::ST_REDUCE, modexp_pkg::ST_MUL_ACC, modexp_pkg::ST_MUL_SQ: begin
        cmd.op = modexp_pkg::DP_MUL_STEP;
      end
      modexp_pkg::ST_BIT: begin
        cmd.op        = modexp_pkg::DP_MUL_START;
        cmd.sel       = status.exp_bit ? modexp_pkg::SEL_ACC : modexp_pkg::SEL_SQ;
        cmd.shift_exp = 1'b1;
      end
      modexp_pkg::ST_SQ_START: begin
        cmd.op  = modexp_pkg::DP_MUL_START;
        cmd.sel = modexp_pkg::SEL_SQ;
      end
      modexp_pkg::ST_FINISH: begin
        if (publish) cmd.op = modexp_pkg::DP_PUBLISH;
      end
      default: begin
        cmd.op = modexp_pkg::DP_NOP;
      end
    endcase
  end

endmodule

### hw/rtl/modexp_dp.sv
// Datapath: configuration registers, operands and the bit-serial modular multiplier.
module modexp_dp #(
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [modexp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [WORD_BITS-1:0]                cfg_data,
  input  logic [WORD_BITS-1:0]                base_value,
  input  modexp_pkg::dp_cmd_t                 cmd,
  output modexp_pkg::dp_status_t              status,
  output logic [WORD_BITS-1:0]                result
);

  localparam int MC_W = $clog2(WORD_BITS);
  localparam int EC_W = $clog2(WORD_BITS + 1);
  localparam int T_W  = WORD_BITS + 2;

  logic [WORD_BITS-1:0]  exponent;
  logic [WORD_BITS-1:0]  modulus;
  logic [WORD_BITS-1:0]  sq;
  logic [WORD_BITS-1:0]  acc;
  logic [WORD_BITS-1:0]  prod;
  logic [WORD_BITS-1:0]  xop;
  logic [WORD_BITS-1:0]  yop;
  logic [WORD_BITS-1:0]  ereg;
  logic [MC_W-1:0]       mcnt;
  logic [EC_W-1:0]       ecnt;
  modexp_pkg::mul_sel_t  dest;

  logic [T_W-1:0]        t_sum;
  logic [T_W-1:0]        m1;
  logic [T_W-1:0]        m2;
  logic [T_W-1:0]        t_red;
  logic [WORD_BITS-1:0]  prod_next;

  // One multiplier step: (2*prod + ybit*x) stays below 3*modulus, so at most
  // two subtractions of the modulus bring it back into range.
  assign m1    = {2'b00, modulus};
  assign m2    = {1'b0, modulus, 1'b0};
  assign t_sum = {1'b0, prod, 1'b0} + (yop[WORD_BITS-1] ? {2'b00, xop} : '0);

  always_comb begin
    if (t_sum >= m2) begin
      t_red = t_sum - m2;
    end else if (t_sum >= m1) begin
      t_red = t_sum - m1;
    end else begin
      t_red = t_sum;
    end
  end

  assign prod_next = t_red[WORD_BITS-1:0];

  assign status.mul_last = (mcnt == MC_W'(WORD_BITS - 1));
  assign status.exp_bit  = ereg[0];
  assign status.exp_done = (ecnt == EC_W'(WORD_BITS));

  // Configuration registers; a zero modulus is not accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= '0;
      modulus  <= WORD_BITS'(1);
    end else if (cfg_we) begin
      if (cfg_index == modexp_pkg::REG_EXPONENT) begin
        exponent <= cfg_data;
      end else if (cfg_index == modexp_pkg::REG_MODULUS) begin
        if (cfg_data != '0) modulus <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      modexp_pkg::DP_LOAD: begin
        // The base is reduced as base * 1 mod m, scanning the base bits.
        xop  <= WORD_BITS'(1);
        yop  <= base_value;
        prod <= '0;
        mcnt <= '0;
        dest <= modexp_pkg::SEL_SQ;
        acc  <= (modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
        ereg <= exponent;
        ecnt <= '0;
      end
      modexp_pkg::DP_MUL_START: begin
        xop  <= sq;
        yop  <= (cmd.sel == modexp_pkg::SEL_ACC) ? acc : sq;
        prod <= '0;
        mcnt <= '0;
        dest <= cmd.sel;
        if (cmd.shift_exp) begin
          ereg <= ereg >> 1;
          ecnt <= ecnt + EC_W'(1);
        end
      end
      modexp_pkg::DP_MUL_STEP: begin
        prod <= prod_next;
        yop  <= yop << 1;
        mcnt <= mcnt + MC_W'(1);
        if (status.mul_last) begin
          if (dest == modexp_pkg::SEL_ACC) begin
            acc <= prod_next;
          end else begin
            sq <= prod_next;
          end
        end
      end
      modexp_pkg::DP_PUBLISH: begin
        result <= acc;
      end
      default: begin
      end
    endcase
  end

endmodule

### verif/modular_exponentiation_tb.sv
// Self-checking testbench of the modular exponentiation block.
module modular_exponentiation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W = modexp_pkg::DATA_W;
  localparam int WORD_BITS = 32;

  // ITEM_CYCLES is the length of the slowest item. With about 290 items, random
  // stalls and the clearing wait at the end, a correct run stays well inside
  // CYCLE_LIMIT.
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int ITEM_CYCLES = 2 + WORD_BITS + 2 * WORD_BITS * (WORD_BITS + 1);
  localparam int TAIL_CYCLES = ITEM_CYCLES + 64;

  // The random part runs in phases. Each phase programs a fresh exponent and
  // modulus and then streams a handful of bases.
  localparam int PHASE_COUNT = 30;
  localparam int PHASE_ITEMS = 9;
  localparam int QUIET_PHASES = 8;

  // One accepted base together with the settings it was accepted under and
  // the power that the block must return for it.
  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] exp;
    logic [DATA_W-1:0] modulus;
    logic [DATA_W-1:0] power;
  } power_check_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  modexp_base_if                          operand_if ();
  modexp_result_if                        result_if ();
  modexp_cfg_if #(.WORD_BITS(WORD_BITS))  cfg_if ();

  modular_exponentiation #(
    .WORD_BITS (WORD_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand_if),
    .result  (result_if),
    .cfg     (cfg_if)
  );

  // Shadow copies of the two registers, kept in step with every write beat.
  logic [DATA_W-1:0] exp_shadow = '0;
  logic [DATA_W-1:0] mod_shadow = DATA_W'(1);

  // Powers that are owed by the block, oldest first.
  power_check_t pending_powers[$];

  // When set, both the base sender and the result receiver pause at random.
  bit idle_on = 1'b0;

  int errors = 0;
  int bases_sent = 0;
  int powers_checked = 0;
  int reg_writes = 0;
  int configs_used = 0;
  int cycle_count = 0;

  // Clock with an 8 ns period. The first edge is a rising one at 4 ns.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs or loses a beat.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d powers still owed", cycle_count,
               pending_powers.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Right-to-left square-and-multiply. Since the modulus fits in 32 bits,
  // every product of two reduced values fits in 64 bits, so plain 64-bit
  // arithmetic gives the exact residue at each step.
  function automatic logic [DATA_W-1:0] expected_power(input logic [DATA_W-1:0] base,
                                                       input logic [DATA_W-1:0] exp,
                                                       input logic [DATA_W-1:0] modulus);
    logic [63:0] m;
    logic [63:0] square;
    logic [63:0] acc;
    int          i;
    m = {32'd0, modulus};
    square = {32'd0, base} % m;
    acc = 64'd1 % m;
    for (i = 0; i < DATA_W; i++) begin
      if (exp[i]) begin
        acc = (acc * square) % m;
      end
      square = (square * square) % m;
    end
    return acc[DATA_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Result side. Ready is changed at the falling edge, so a beat seen at the
  // rising edge always reflects settled values on both sides.
  always @(negedge clk) begin
    result_if.ready <= !(idle_on && ($urandom_range(99) < 25));
  end

  always @(posedge clk) begin : check_powers
    power_check_t owed;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_powers.size() == 0) begin
        report_mismatch($sformatf("result beat %h with no base outstanding",
                                  result_if.power_result));
      end else begin
        owed = pending_powers.pop_front();
        powers_checked++;
        if (result_if.power_result !== owed.power) begin
          report_mismatch($sformatf("%h ^ %h mod %h: got %h, want %h", owed.base,
                                    owed.exp, owed.modulus, result_if.power_result,
                                    owed.power));
        end
      end
    end
  end

  // Sends one base. It is entered at a falling edge and returns at the falling
  // edge after the beat, leaving valid high so that back-to-back bases need no
  // drop in between.
  task automatic send_base(input logic [DATA_W-1:0] base);
    while (idle_on && ($urandom_range(99) < 25)) begin
      operand_if.valid <= 1'b0;
      @(negedge clk);
    end
    operand_if.valid <= 1'b1;
    operand_if.base_value <= base;
    do @(posedge clk); while (!operand_if.ready);
    pending_powers.push_back('{base, exp_shadow, mod_shadow,
                               expected_power(base, exp_shadow, mod_shadow)});
    bases_sent++;
    @(negedge clk);
  endtask

  // One register write beat. A zero written to the modulus is dropped by the
  // block, and the shadow does the same.
  task automatic write_reg(input logic [modexp_pkg::CFG_INDEX_W-1:0] index,
                           input logic [DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    if (index == modexp_pkg::REG_EXPONENT) begin
      exp_shadow = data;
    end else if (index == modexp_pkg::REG_MODULUS && data != '0) begin
      mod_shadow = data;
    end
    reg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [DATA_W-1:0] exp, input logic [DATA_W-1:0] modulus);
    write_reg(modexp_pkg::REG_EXPONENT, exp);
    write_reg(modexp_pkg::REG_MODULUS, modulus);
    configs_used++;
  endtask

  // Drops valid and waits until every owed power has come back. Each base
  // always yields a result, so the block is idle once the queue is empty.
  task automatic settle();
    operand_if.valid <= 1'b0;
    @(negedge clk);
    while (pending_powers.size() != 0) @(negedge clk);
  endtask

  // Mix of edge values and uniform values for registers and bases.
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return DATA_W'(1);
      2: return '1;
      3: return DATA_W'($urandom_range(2, 16));
      4: return {1'b1, (DATA_W-1)'($urandom)};
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Straight out of reset the exponent is zero and the modulus is one, so
  // every base must come back as zero.
  task automatic test_reset_values();
    send_base('0);
    send_base('1);
    settle();
  endtask

  // A zero exponent leaves the accumulator at one whatever the base is.
  task automatic test_zero_exponent();
    set_config('0, '1);
    send_base('0);
    send_base(DATA_W'(5));
    send_base('1);
    settle();
  endtask

  // A modulus of one forces zero even with every exponent bit set.
  task automatic test_modulus_one();
    set_config('1, DATA_W'(1));
    send_base(DATA_W'(7));
    send_base('1);
    settle();
  endtask

  // Writing zero to the modulus must leave the previous value in place.
  task automatic test_zero_modulus_ignored();
    set_config(DATA_W'(3), DATA_W'(13));
    write_reg(modexp_pkg::REG_MODULUS, '0);
    send_base(DATA_W'(2));
    send_base(DATA_W'(13));
    send_base(DATA_W'(20));
    settle();
  endtask

  // Largest operands everywhere, a base above the modulus, the smallest
  // modulus that is not trivial, and a prime modulus where Fermat's little
  // theorem pins the answer to one. The block drains before each new setting.
  task automatic test_extremes();
    set_config('1, '1);
    send_base(32'hFFFF_FFFE);
    send_base('1);
    send_base(DATA_W'(2));
    settle();
    set_config(DATA_W'(1), DATA_W'(2));
    send_base('1);
    send_base('0);
    settle();
    set_config(32'hFFFF_FFFA, 32'hFFFF_FFFB);
    send_base(32'h1234_5678);
    send_base(32'hFFFF_FFFC);
    settle();
    set_config(32'h8000_0000, 32'h8000_0001);
    send_base(32'hDEAD_BEEF);
    settle();
  endtask

  // Random phases. The first few run without any idling on either side; the
  // rest pause both the sender and the receiver about a quarter of the time.
  task automatic test_random_phases();
    logic [DATA_W-1:0] exp;
    logic [DATA_W-1:0] modulus;
    logic [DATA_W-1:0] base;
    int                phase;
    int                item;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      idle_on = (phase >= QUIET_PHASES);
      exp = pick_word();
      modulus = pick_word();
      if ($urandom_range(1)) begin
        set_config(exp, modulus);
      end else begin
        write_reg(modexp_pkg::REG_MODULUS, modulus);
        write_reg(modexp_pkg::REG_EXPONENT, exp);
        configs_used++;
      end
      // Now and then a stray zero write to the modulus, which must not stick.
      if ($urandom_range(7) == 0) begin
        write_reg(modexp_pkg::REG_MODULUS, '0);
      end
      for (item = 0; item < PHASE_ITEMS; item++) begin
        case ($urandom_range(9))
          0: base = pick_word();
          1: base = mod_shadow * DATA_W'($urandom_range(1, 3));
          2: base = mod_shadow - DATA_W'(1);
          default: base = DATA_W'($urandom);
        endcase
        send_base(base);
      end
      settle();
    end
  endtask

  initial begin
    operand_if.valid = 1'b0;
    operand_if.base_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = modexp_pkg::REG_EXPONENT;
    cfg_if.data = '0;
    result_if.ready = 1'b0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_values();
    test_zero_exponent();
    test_modulus_one();
    test_zero_modulus_ignored();
    test_extremes();
    test_random_phases();

    // Give the block a full item's worth of cycles to show any stray beat.
    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_powers.size() != 0) begin
      report_mismatch($sformatf("%0d powers never returned", pending_powers.size()));
    end

    $display("run covered %0d bases and %0d checked powers over %0d settings",
             bases_sent, powers_checked, configs_used);
    $display("%0d register writes, %0d mismatches, %0d cycles", reg_writes, errors,
             cycle_count);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### modular_exponentiation.f
hw/rtl/modexp_pkg.sv
hw/rtl/modexp_ifs.sv
hw/rtl/modexp_ctrl.sv
hw/rtl/modexp_dp.sv
hw/rtl/modular_exponentiation.sv
verif/modular_exponentiation_tb.sv
